>>> rtl/fbpa_pkg.sv
// Package for the fixed block pool allocator: field widths, codes, payload structs.
// No dependencies; imported by every module of the block.
package fbpa_pkg;

  // Field widths
  localparam int CMD_W    = 1;
  localparam int BIDX_W   = 10;
  localparam int STATUS_W = 2;
  localparam int OFFS_W   = 27;
  localparam int FREE_W   = 11;
  localparam int BBYTES_W = 16;
  localparam int BLOCKS_W = 11;

  // Flag store organization
  localparam int FLAG_W     = 32;
  localparam int FLAG_BIT_W = 5;

  // Block stride (header + payload) fits in 17 bits for headers up to 64 bytes
  localparam int STEP_W = 17;

  // Pool header ahead of block 0
  localparam int POOL_HEADER = 8;

  // Defaults
  localparam int MAX_BLOCKS_DEF   = 1024;
  localparam int HEADER_BYTES_DEF = 8;
  localparam int RESET_BBYTES     = 64;
  localparam int RESET_BLOCKS     = 1024;

  // APB register map
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic REG_BLOCK_BYTES = 1'b0;
  localparam logic REG_BLOCKS      = 1'b1;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_BAD  = 2'd2
  } status_e;

  typedef struct packed {
    cmd_e                cmd;
    logic [BIDX_W-1:0]   block_index;
  } req_t;

  typedef struct packed {
    status_e             status;
    logic [BIDX_W-1:0]   granted_index;
    logic [OFFS_W-1:0]   payload_offset;
    logic [FREE_W-1:0]   free_left;
  } rsp_t;

endpackage

>>> rtl/fbpa_scan.sv
// First-free search over one 32-bit word of the flag store.
// Depends on fbpa_pkg; used by fbpa_engine.
module fbpa_scan import fbpa_pkg::*; #(
  parameter int MAX_BLOCKS = MAX_BLOCKS_DEF,
  localparam int Words     = (MAX_BLOCKS + FLAG_W - 1) / FLAG_W,
  localparam int WordW     = (Words > 1) ? $clog2(Words) : 1,
  localparam int CntW      = $clog2(MAX_BLOCKS + 1)
) (
  input  logic [FLAG_W-1:0]                 flags_i,
  input  logic [WordW-1:0]                  word_i,
  input  logic [CntW-1:0]                   n_i,
  output logic                              found_o,
  output logic [FLAG_BIT_W-1:0]             pos_o
);

  localparam int IdxW  = WordW + FLAG_BIT_W;
  localparam int CW    = (CntW > IdxW) ? CntW : IdxW;

  logic [FLAG_W-1:0] free_w;
  logic [FLAG_W-1:0] v;

  // Bits past the block count count as used.
  always_comb begin
    for (int b = 0; b < FLAG_W; b++) begin
      free_w[b] = ~flags_i[b] &
                  (CW'({word_i, FLAG_BIT_W'(b)}) < CW'(n_i));
    end
  end

  // Binary search for the lowest set bit, halving the window each step.
  always_comb begin
    v     = free_w;
    pos_o = '0;
    for (int k = FLAG_BIT_W - 1; k >= 0; k--) begin
      if ((v & ((32'd1 << (32'd1 << k)) - 32'd1)) == '0) begin
        pos_o[k] = 1'b1;
        v        = v >> (32'd1 << k);
      end
    end
  end

  assign found_o = |free_w;

endmodule

>>> rtl/fbpa_engine.sv
// Allocation sequencer: flag store, free count, word scan, offset multiply.
// Depends on fbpa_pkg and fbpa_scan.
module fbpa_engine import fbpa_pkg::*; #(
  parameter int MAX_BLOCKS   = MAX_BLOCKS_DEF,
  parameter int HEADER_BYTES = HEADER_BYTES_DEF,
  localparam int CntW        = $clog2(MAX_BLOCKS + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  init_i,
  input  logic [CntW-1:0]       eff_n_i,
  input  logic [BBYTES_W-1:0]   block_bytes_i,
  input  logic                  req_valid_i,
  output logic                  req_ready_o,
  input  req_t                  req_i,
  input  logic                  out_free_i,
  output logic                  rsp_valid_o,
  output rsp_t                  rsp_o
);

  localparam int Words = (MAX_BLOCKS + FLAG_W - 1) / FLAG_W;
  localparam int WordW = (Words > 1) ? $clog2(Words) : 1;
  localparam int IdxW  = WordW + FLAG_BIT_W;
  localparam int CW0   = (CntW > IdxW) ? CntW : IdxW;
  localparam int CW    = (CW0 > BIDX_W) ? CW0 : BIDX_W;
  localparam int RstN  = (RESET_BLOCKS > MAX_BLOCKS) ? MAX_BLOCKS : RESET_BLOCKS;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_FREE = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_ADD  = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0]             state_q, state_d;
  logic [BIDX_W-1:0]      idx_q, idx_d;
  logic [WordW-1:0]       word_q, word_d;
  logic [IdxW-1:0]        gidx_q, gidx_d;
  status_e                status_q, status_d;
  logic [OFFS_W-1:0]      prod_q, prod_d;
  logic [OFFS_W-1:0]      offset_q, offset_d;
  logic [CntW-1:0]        free_cnt_q, free_cnt_d;

  // Flag store
  logic [FLAG_W-1:0]      flag_mem [Words];
  logic [Words-1:0]       row_vld_q;
  logic [FLAG_W-1:0]      rd_word_q;
  logic                   rd_vld_q;
  logic                   rd_en, wr_en;
  logic [WordW-1:0]       rd_addr, wr_addr;
  logic [FLAG_W-1:0]      wr_data;
  logic [FLAG_W-1:0]      flags;

  logic                   found;
  logic [FLAG_BIT_W-1:0]  pos;
  logic [CW-1:0]          idx_ext, req_idx_ext;
  logic [STEP_W-1:0]      step;
  logic                   accept;

  assign accept      = req_valid_i & req_ready_o;
  assign req_ready_o = (state_q == S_IDLE) & ~init_i;
  assign idx_ext     = CW'(idx_q);
  assign req_idx_ext = CW'(req_i.block_index);
  assign step        = STEP_W'(HEADER_BYTES) + STEP_W'(block_bytes_i);

  // A row never written since init reads as all free.
  assign flags = rd_vld_q ? rd_word_q : '0;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      flag_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_word_q <= flag_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
      rd_vld_q  <= 1'b0;
    end else begin
      if (init_i) begin
        row_vld_q <= '0;
      end else if (wr_en) begin
        row_vld_q[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_q <= row_vld_q[rd_addr];
      end
    end
  end

  fbpa_scan #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_scan (
    .flags_i (flags),
    .word_i  (word_q),
    .n_i     (eff_n_i),
    .found_o (found),
    .pos_o   (pos)
  );

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    word_d     = word_q;
    gidx_d     = gidx_q;
    status_d   = status_q;
    prod_d     = prod_q;
    offset_d   = offset_q;
    free_cnt_d = free_cnt_q;
    rd_en      = 1'b0;
    rd_addr    = word_q;
    wr_en      = 1'b0;
    wr_addr    = word_q;
    wr_data    = flags;

    unique case (state_q)
      S_IDLE: begin
        if (init_i) begin
          free_cnt_d = eff_n_i;
        end else if (accept) begin
          idx_d    = req_i.block_index;
          gidx_d   = '0;
          offset_d = '0;
          if (req_i.cmd == CMD_ALLOC) begin
            if (free_cnt_q == '0) begin
              status_d = ST_FULL;
              state_d  = S_FIN;
            end else begin
              word_d  = '0;
              rd_en   = 1'b1;
              rd_addr = '0;
              state_d = S_SCAN;
            end
          end else begin
            rd_en   = 1'b1;
            rd_addr = req_idx_ext[WordW+FLAG_BIT_W-1:FLAG_BIT_W];
            state_d = S_FREE;
          end
        end
      end
      S_SCAN: begin
        if (found) begin
          gidx_d     = {word_q, pos};
          wr_en      = 1'b1;
          wr_data    = flags | (FLAG_W'(1) << pos);
          free_cnt_d = free_cnt_q - 1'b1;
          status_d   = ST_OK;
          state_d    = S_MUL;
        end else if (word_q == WordW'(Words - 1)) begin
          status_d = ST_FULL;
          state_d  = S_FIN;
        end else begin
          word_d  = WordW'(word_q + 1'b1);
          rd_en   = 1'b1;
          rd_addr = WordW'(word_q + 1'b1);
        end
      end
      S_FREE: begin
        wr_addr = idx_ext[WordW+FLAG_BIT_W-1:FLAG_BIT_W];
        if ((idx_ext < CW'(eff_n_i)) && flags[idx_q[FLAG_BIT_W-1:0]]) begin
          wr_en      = 1'b1;
          wr_data    = flags & ~(FLAG_W'(1) << idx_q[FLAG_BIT_W-1:0]);
          free_cnt_d = free_cnt_q + 1'b1;
          status_d   = ST_OK;
        end else begin
          status_d = ST_BAD;
        end
        state_d = S_FIN;
      end
      S_MUL: begin
        prod_d  = OFFS_W'(gidx_q * step);
        state_d = S_ADD;
      end
      S_ADD: begin
        offset_d = prod_q + OFFS_W'(POOL_HEADER + HEADER_BYTES);
        state_d  = S_FIN;
      end
      S_FIN: begin
        if (out_free_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      free_cnt_q <= CntW'(RstN);
      status_q   <= ST_OK;
    end else begin
      state_q    <= state_d;
      free_cnt_q <= free_cnt_d;
      status_q   <= status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    word_q   <= word_d;
    gidx_q   <= gidx_d;
    prod_q   <= prod_d;
    offset_q <= offset_d;
  end

  assign rsp_valid_o           = (state_q == S_FIN);
  assign rsp_o.status          = status_q;
  assign rsp_o.granted_index   = BIDX_W'(gidx_q);
  assign rsp_o.payload_offset  = offset_q;
  assign rsp_o.free_left       = FREE_W'(free_cnt_q);

endmodule

>>> rtl/fixed_block_pool_allocator.sv
// Top level of the fixed block pool allocator: APB registers, output register.
// Depends on fbpa_pkg and fbpa_engine.
//
// Usage:
//   Request channel (in_valid_i/in_ready_o/in_data_i): one transfer is an
//   allocate or a free command. Response channel (out_valid_o/out_ready_i/
//   out_data_o): exactly one transfer per request, in request order.
//   Steps from accept to response: an allocate with a zero free count
//   goes straight to the response state; an allocate scans from word 0
//   up to the first free flag, then multiplies and adds the offset; a
//   free reads and updates one flag word. Each response is registered.
//   The flag store is scanned one 32-flag word per cycle through a single
//   search unit.
//   One request is in work at a time; in_ready_o is high only while idle.
//   A finished response sits in the output register; the next request can
//   be taken meanwhile, but its result waits until out_ready_i drains it.
//   Reset: block_bytes = 64, blocks_in_use = 1024, all blocks free. The
//   flag rows carry valid bits, so no clearing pass is needed.
//   Writing either register re-initializes the pool (flags clear, free
//   count reloads if idle); in_ready_o drops for the cycle after the write.
module fixed_block_pool_allocator import fbpa_pkg::*; #(
  parameter int MAX_BLOCKS   = MAX_BLOCKS_DEF,
  parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // request channel
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  req_t                    in_data_i,
  // response channel
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output rsp_t                    out_data_o,
  // APB configuration port
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [APB_ADDR_W-1:0]   paddr,
  input  logic [APB_DATA_W-1:0]   pwdata,
  output logic [APB_DATA_W-1:0]   prdata,
  output logic                    pready
);

  localparam int CntW = $clog2(MAX_BLOCKS + 1);
  localparam int NW   = (CntW > BLOCKS_W) ? CntW : BLOCKS_W;

  logic [BBYTES_W-1:0] block_bytes_q;
  logic [BLOCKS_W-1:0] blocks_q;
  logic                init_q;
  logic                cfg_wr;
  logic [NW-1:0]       blocks_ext;
  logic [CntW-1:0]     eff_n;

  logic                out_valid_q;
  rsp_t                out_q;
  logic                rsp_valid;
  rsp_t                rsp;
  logic                out_free;

  // Register write on the APB access phase; register index is paddr[2].
  assign cfg_wr = psel & penable & pwrite & pready;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_bytes_q <= BBYTES_W'(RESET_BBYTES);
      blocks_q      <= BLOCKS_W'(RESET_BLOCKS);
      init_q        <= 1'b0;
    end else begin
      init_q <= cfg_wr;
      if (cfg_wr) begin
        unique case (paddr[2])
          REG_BLOCK_BYTES: block_bytes_q <= pwdata[BBYTES_W-1:0];
          REG_BLOCKS:      blocks_q      <= pwdata[BLOCKS_W-1:0];
          default:         block_bytes_q <= block_bytes_q;
        endcase
      end
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_BLOCK_BYTES: prdata = APB_DATA_W'(block_bytes_q);
      REG_BLOCKS:      prdata = APB_DATA_W'(blocks_q);
      default:         prdata = '0;
    endcase
  end

  // Effective block count: zero reads as one, clamp to the pool capacity.
  assign blocks_ext = NW'(blocks_q);
  always_comb begin
    priority if (blocks_ext == '0) begin
      eff_n = CntW'(1);
    end else if (blocks_ext > NW'(MAX_BLOCKS)) begin
      eff_n = CntW'(MAX_BLOCKS);
    end else begin
      eff_n = CntW'(blocks_ext);
    end
  end

  fbpa_engine #(
    .MAX_BLOCKS   (MAX_BLOCKS),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_engine (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .init_i        (init_q),
    .eff_n_i       (eff_n),
    .block_bytes_i (block_bytes_q),
    .req_valid_i   (in_valid_i),
    .req_ready_o   (in_ready_o),
    .req_i         (in_data_i),
    .out_free_i    (out_free),
    .rsp_valid_o   (rsp_valid),
    .rsp_o         (rsp)
  );

  // Output register decouples the engine from a stalled receiver.
  assign out_free = ~out_valid_q | out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= rsp_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && rsp_valid) begin
      out_q <= rsp;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> rtl/fbpa_checker.sv
// Port-level assertions for the fixed block pool allocator, bound to the top.
// Depends on fbpa_pkg and fixed_block_pool_allocator.
module fbpa_checker import fbpa_pkg::*; #(
  parameter int MAX_BLOCKS = MAX_BLOCKS_DEF
) (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input logic out_valid_o,
  input logic out_ready_i,
  input rsp_t out_data_o
);

  // Stalled response holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("response changed while stalled");

  // One request in work at a time.
  a_one_in_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request taken while another is in work");

  // Failed requests carry no grant.
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status != ST_OK) |->
      (out_data_o.granted_index == '0) && (out_data_o.payload_offset == '0))
    else $error("grant fields set on a failed request");

  // Free count never exceeds the pool capacity.
  a_free_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (32'(out_data_o.free_left) <= 32'(MAX_BLOCKS)))
    else $error("free count above capacity");

endmodule

bind fixed_block_pool_allocator fbpa_checker #(
  .MAX_BLOCKS (MAX_BLOCKS)
) u_fbpa_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

>>> tb/tb_top.sv
// Self-checking bench for fixed_block_pool_allocator: directed and random alloc/free traffic
// against an in-bench pool predictor. Depends on fbpa_pkg and the RTL of the block only.
module tb_top;
  import fbpa_pkg::*;

  localparam int CLK_HALF     = 2;
  localparam int RESET_CYCLES = 10;
  // Quiet cycles tolerated before the run is declared hung. The longest
  // legitimate quiet stretch is the forced receiver hold plus one scan.
  localparam int QUIET_LIMIT  = 3000;
  localparam int LONG_HOLD    = 400;
  // Worst case scan: 32 words plus pipeline, with margin
  localparam int SETTLE_CYCLES = 48;
  localparam int RANDOM_ROUNDS = 8;
  localparam int ROUND_ITEMS   = 40;
  // Pool size for the fill test: several flag words deep
  localparam int FILL_BLOCKS   = 128;

  localparam logic [APB_ADDR_W-1:0] ADDR_BLOCK_BYTES = APB_ADDR_W'(REG_BLOCK_BYTES) << 2;
  localparam logic [APB_ADDR_W-1:0] ADDR_BLOCKS      = APB_ADDR_W'(REG_BLOCKS) << 2;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  req_t                  in_data;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  rsp_t                  out_data;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  fixed_block_pool_allocator u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #CLK_HALF clk = ~clk;

  // ------------------------------------------------------------------
  // Pool predictor: shadow flags, free count and the two registers.
  // ------------------------------------------------------------------
  bit                  pool_used [MAX_BLOCKS_DEF];
  int unsigned         free_blocks;
  logic [BBYTES_W-1:0] cfg_block_bytes;
  logic [BLOCKS_W-1:0] cfg_blocks;

  rsp_t pending_rsp_q [$];
  int   mismatch_count = 0;

  // Managed block count: zero counts as one, anything past the pool size clamps
  function automatic int unsigned managed_blocks();
    int unsigned n;
    n = cfg_blocks;
    if (n == 0) n = 1;
    if (n > MAX_BLOCKS_DEF) n = MAX_BLOCKS_DEF;
    return n;
  endfunction

  function automatic void pool_clear();
    foreach (pool_used[i]) pool_used[i] = 1'b0;
    free_blocks = managed_blocks();
  endfunction

  // Expected response for one accepted request; updates the shadow pool.
  function automatic rsp_t pool_grant(req_t req);
    rsp_t            rsp;
    int unsigned     n;
    int unsigned     slot;
    int unsigned     i;
    bit              found;
    longint unsigned offs;
    n     = managed_blocks();
    rsp   = '0;
    found = 1'b0;
    slot  = 0;
    rsp.status = ST_OK;
    if (req.cmd == CMD_ALLOC) begin
      if (free_blocks != 0) begin
        for (i = 0; i < n && !found; i++) begin
          if (!pool_used[i]) begin
            found = 1'b1;
            slot  = i;
          end
        end
      end
      if (found) begin
        pool_used[slot] = 1'b1;
        free_blocks--;
        // pool header, then slot strides of header + payload, then this block's header
        offs = 64'(POOL_HEADER)
             + 64'(slot) * (64'(HEADER_BYTES_DEF) + 64'(cfg_block_bytes))
             + 64'(HEADER_BYTES_DEF);
        rsp.granted_index  = slot[BIDX_W-1:0];
        rsp.payload_offset = offs[OFFS_W-1:0];
      end else begin
        rsp.status = ST_FULL;
      end
    end else begin
      // out of range or not in use: flagged, nothing changes
      if (req.block_index < n && pool_used[req.block_index]) begin
        pool_used[req.block_index] = 1'b0;
        free_blocks++;
      end else begin
        rsp.status = ST_BAD;
      end
    end
    rsp.free_left = free_blocks[FREE_W-1:0];
    return rsp;
  endfunction

  // ------------------------------------------------------------------
  // Monitor: at each rising edge, check a response transfer first, then
  // predict a request transfer. Responses trail requests by the engine
  // state and output register, so no pop needs the same edge's push.
  // ------------------------------------------------------------------
  always @(posedge clk) begin
    rsp_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (pending_rsp_q.size() == 0) begin
          $error("response transfer with nothing expected: %p", out_data);
          mismatch_count++;
        end else begin
          want = pending_rsp_q.pop_front();
          if (out_data.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_data.status);
            mismatch_count++;
          end
          if (out_data.granted_index !== want.granted_index) begin
            $error("granted_index: expected %0d, got %0d",
                   want.granted_index, out_data.granted_index);
            mismatch_count++;
          end
          if (out_data.payload_offset !== want.payload_offset) begin
            $error("payload_offset: expected %0d, got %0d",
                   want.payload_offset, out_data.payload_offset);
            mismatch_count++;
          end
          if (out_data.free_left !== want.free_left) begin
            $error("free_left: expected %0d, got %0d", want.free_left, out_data.free_left);
            mismatch_count++;
          end
        end
      end
      if (in_valid && in_ready) pending_rsp_q.push_back(pool_grant(in_data));
    end
  end

  // ------------------------------------------------------------------
  // Receiver: stall pattern that switches between always ready, coin flip
  // and mostly stalled. A long hold request overrides it and holds out_ready
  // low so the block backs up into its request channel.
  // ------------------------------------------------------------------
  bit long_hold_req = 1'b0;
  int hold_left     = 0;
  int rx_mode       = 0;
  int mode_left     = 0;

  always @(negedge clk) begin
    if (long_hold_req) begin
      hold_left     = LONG_HOLD;
      long_hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready = 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode   = $urandom_range(0, 2);
        mode_left = $urandom_range(16, 96);
      end
      mode_left--;
      case (rx_mode)
        0:       out_ready = 1'b1;
        1:       out_ready = $urandom_range(0, 1);
        default: out_ready = ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // ------------------------------------------------------------------
  // Watchdog: ends the run once its quiet counter, cleared by a transfer, hits QUIET_LIMIT.
  // ------------------------------------------------------------------
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
          (psel && penable))
        quiet = 0;
      else
        quiet++;
    end
    $display("** fixed_block_pool_allocator: FAILED **");
    $finish;
  end

  // ------------------------------------------------------------------
  // Request sender. Works in bursts of random length with random idle
  // gaps between them; no_gaps forces back-to-back offers. Every task
  // below is entered and left at a falling edge.
  // ------------------------------------------------------------------
  int burst_left = 0;
  bit no_gaps    = 1'b0;

  task automatic send_req(input cmd_e cmd, input logic [BIDX_W-1:0] idx);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = no_gaps ? 0 : (($urandom_range(0, 7) == 0) ? $urandom_range(8, 30)
                                                       : $urandom_range(0, 4));
      if (gap != 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid            = 1'b1;
    in_data.cmd         = cmd;
    in_data.block_index = idx;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic alloc_req();
    send_req(CMD_ALLOC, BIDX_W'($urandom()));
  endtask

  task automatic free_req(input logic [BIDX_W-1:0] idx);
    send_req(CMD_FREE, idx);
  endtask

  // Sender pause: drop valid, wait for every response, then let the
  // block settle for the longest scan it could still be running.
  task automatic drain();
    in_valid = 1'b0;
    while (pending_rsp_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // One APB transfer: setup cycle, then access until pready.
  task automatic apb_cycle(input bit is_write, input logic [APB_ADDR_W-1:0] addr,
                           input logic [APB_DATA_W-1:0] wdata,
                           output logic [APB_DATA_W-1:0] rdata);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = is_write;
    paddr   = addr;
    pwdata  = wdata;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // Reconfigure while idle; each write re-initializes the pool. Both
  // registers are read back after being written.
  task automatic set_pool(input logic [BBYTES_W-1:0] bytes, input logic [BLOCKS_W-1:0] count);
    logic [APB_DATA_W-1:0] rd;
    drain();
    apb_cycle(1'b1, ADDR_BLOCK_BYTES, APB_DATA_W'(bytes), rd);
    cfg_block_bytes = bytes;
    pool_clear();
    apb_cycle(1'b1, ADDR_BLOCKS, APB_DATA_W'(count), rd);
    cfg_blocks = count;
    pool_clear();
    apb_cycle(1'b0, ADDR_BLOCK_BYTES, '0, rd);
    if (rd !== APB_DATA_W'(bytes)) begin
      $error("block_bytes readback: expected %0d, got %0d", bytes, rd);
      mismatch_count++;
    end
    apb_cycle(1'b0, ADDR_BLOCKS, '0, rd);
    if (rd !== APB_DATA_W'(count)) begin
      $error("blocks_in_use readback: expected %0d, got %0d", count, rd);
      mismatch_count++;
    end
  endtask

  // Some block the predictor holds as in use, else any index in range
  function automatic logic [BIDX_W-1:0] pick_used_block();
    int unsigned n;
    int unsigned start;
    int unsigned k;
    n     = managed_blocks();
    start = $urandom_range(0, n - 1);
    for (k = 0; k < n; k++) begin
      if (pool_used[(start + k) % n]) return BIDX_W'((start + k) % n);
    end
    return BIDX_W'(start);
  endfunction

  // ------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------

  // Reset values: 64-byte blocks, 1024 blocks, all free
  task automatic test_reset_state();
    alloc_req();
    alloc_req();
    alloc_req();
    free_req(10'd1);
    alloc_req();              // lowest free again: block 1
    free_req(10'h3FF);        // in range, never used
    free_req(10'd0);
    free_req(10'd0);          // double free
  endtask

  // Small pool at the largest block size: full pool and bad frees
  task automatic test_pool_full();
    set_pool(16'hFFFF, 11'd3);
    repeat (4) alloc_req();   // last one finds the pool full
    free_req(10'd2);
    free_req(10'd2);          // already free
    free_req(10'd3);          // past the managed count
    free_req(10'h3FF);
    alloc_req();
  endtask

  // Block count zero (one block) and above the pool size (clamped); zero byte blocks
  task automatic test_count_limits();
    set_pool(16'd0, 11'd0);
    alloc_req();              // header-only block 0
    alloc_req();              // full
    free_req(10'd1);          // out of range
    free_req(10'd0);
    set_pool(16'd1, 11'h7FF);
    alloc_req();
    free_req(10'h3FF);
    free_req(10'h200);
  endtask

  // Fill a pool several flag words deep so the scan walks past the first words
  task automatic test_fill_pool();
    set_pool(16'($urandom()), 11'(FILL_BLOCKS));
    repeat (FILL_BLOCKS + 1) alloc_req();
    free_req(BIDX_W'(FILL_BLOCKS - 1));
    free_req(BIDX_W'(FILL_BLOCKS / 2));
    free_req(10'd0);
    repeat (4) alloc_req();
  endtask

  // Receiver holds off for a long stretch while requests keep coming
  task automatic test_backpressure();
    set_pool(16'($urandom_range(1, 255)), 11'd8);
    long_hold_req = 1'b1;
    no_gaps       = 1'b1;
    repeat (24) begin
      if ($urandom_range(0, 1)) alloc_req();
      else free_req(pick_used_block());
    end
    no_gaps = 1'b0;
    drain();
  endtask

  // Mostly well-formed alloc/free mixes with random sizes, plus noise
  task automatic test_random_traffic();
    logic [BBYTES_W-1:0] bytes;
    logic [BLOCKS_W-1:0] count;
    int alloc_pct;
    int roll;
    repeat (RANDOM_ROUNDS) begin
      case ($urandom_range(0, 3))
        0:       bytes = 16'd0;
        1:       bytes = 16'hFFFF;
        2:       bytes = 16'($urandom_range(1, 255));
        default: bytes = 16'($urandom());
      endcase
      case ($urandom_range(0, 5))
        0:       count = 11'($urandom_range(0, 1));
        1, 2:    count = 11'($urandom_range(2, 8));
        3, 4:    count = 11'($urandom_range(9, 40));
        default: count = 11'($urandom_range(41, 2047));
      endcase
      set_pool(bytes, count);
      alloc_pct = $urandom_range(30, 70);
      repeat (ROUND_ITEMS) begin
        roll = $urandom_range(0, 99);
        if (roll < alloc_pct) alloc_req();
        else if (roll < 88) free_req(pick_used_block());
        else free_req(BIDX_W'($urandom()));
      end
    end
  endtask

  initial begin
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    cfg_block_bytes = BBYTES_W'(RESET_BBYTES);
    cfg_blocks      = BLOCKS_W'(RESET_BLOCKS);
    pool_clear();
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_reset_state();
    test_pool_full();
    test_count_limits();
    test_fill_pool();
    test_backpressure();
    test_random_traffic();
    drain();

    if (mismatch_count == 0) begin
      $display("** fixed_block_pool_allocator: PASSED **");
    end else begin
      $display("** fixed_block_pool_allocator: FAILED **");
    end
    $finish;
  end

endmodule
